@@ hdl/angu_pkg.sv @@
// Shared types, codes and saturating helpers for the active node grid update block.
package angu_pkg;

	localparam logic [2:0] ACT_SCATTER   = 3'd0;
	localparam logic [2:0] ACT_CONNECT   = 3'd1;
	localparam logic [2:0] ACT_INJECT    = 3'd2;
	localparam logic [2:0] ACT_SET_FLAGS = 3'd3;
	localparam logic [2:0] ACT_LOAD_COEF = 3'd4;

	localparam logic [1:0] KIND_DONE      = 2'd0;
	localparam logic [1:0] KIND_ACTIVATED = 2'd1;
	localparam logic [1:0] KIND_RETIRED   = 2'd2;
	localparam logic [1:0] KIND_ACTIVE    = 2'd3;

	localparam logic [2:0] REG_SIZE_X  = 3'd0;
	localparam logic [2:0] REG_SIZE_Y  = 3'd1;
	localparam logic [2:0] REG_SIZE_Z  = 3'd2;
	localparam logic [2:0] REG_ABS_THR = 3'd3;
	localparam logic [2:0] REG_REL_THR = 3'd4;

	localparam logic [2:0] PORT_COUNT = 3'd6;
	localparam logic [2:0] LAST_PORT  = 3'd5;

	typedef struct packed {
		logic [2:0]         action;
		logic [3:0]         node_x;
		logic [3:0]         node_y;
		logic [3:0]         node_z;
		logic [2:0]         port_direction;
		logic signed [15:0] reflection;
		logic signed [15:0] transmission;
		logic signed [31:0] source_value;
		logic               may_propagate;
		logic               has_boundary;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] out_x;
		logic [3:0] out_y;
		logic [3:0] out_z;
		logic       toward_positive;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic bound;
		logic prop;
		logic active;
	} flags_t;

	typedef struct packed {
		logic signed [15:0] refl;
		logic signed [15:0] trans;
	} coef_t;

	typedef struct packed {
		coef_t [5:0]       coef;
		logic [5:0][31:0]  pin;
		logic [5:0][31:0]  pout;
		logic [31:0]       volt;
		logic [63:0]       pe;
		logic [63:0]       pk;
		flags_t            flags;
	} node_rec_t;

	typedef struct packed {
		logic [4:0]  sx;
		logic [4:0]  sy;
		logic [4:0]  sz;
		logic [63:0] abs_thr;
		logic [15:0] rel_thr;
	} cfg_t;

	localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
	localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

	function automatic logic [31:0] sat32(input logic signed [49:0] v);
		logic [31:0] r;
		if (v > SAT_MAX) r = 32'h7FFF_FFFF;
		else if (v < SAT_MIN) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

endpackage

@@ hdl/tlm_active_node_grid_update.sv @@
// Items are taken one at a time: a new item is accepted only once the engine is idle again,
// after its last result has been taken by the output register; connect reads each neighbour
// in turn and, on a boundary node, works through the ports one by one.
// Reset: configuration returns to an extent of 16 per axis (clamped to the grid) and zero
// thresholds; then a clearing pass over every cell zeroes the store while items are held off.
module tlm_active_node_grid_update #(
	parameter int GRID_X = 16,
	parameter int GRID_Y = 16,
	parameter int GRID_Z = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  angu_pkg::in_item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output angu_pkg::out_item_t  result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $bits(angu_pkg::node_rec_t);

	logic [4:0]           size_x_q, size_y_q, size_z_q;
	logic [63:0]          abs_thr_q;
	logic [15:0]          rel_thr_q;
	angu_pkg::cfg_t       cfg;
	logic                 clearing_q;
	logic [AW:0]          clr_cnt_q;
	logic                 result_valid_q;
	angu_pkg::out_item_t  result_q;

	logic                 eng_ready, res_valid, slot_free;
	angu_pkg::out_item_t  res;
	logic                 e_rd_en, e_wr_en, wr_en;
	logic [AW-1:0]        e_rd_addr, e_wr_addr, wr_addr;
	angu_pkg::node_rec_t  rd_data, e_wr_data, e_wr_mask, wr_data, wr_mask;

	function automatic logic [4:0] clamp_size(input logic [4:0] v, input int g);
		logic [4:0] r;
		if (v == 5'd0) r = 5'd1;
		else if (32'(v) > g) r = 5'(g);
		else r = v;
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q  <= 5'd16;
			size_y_q  <= 5'd16;
			size_z_q  <= 5'd16;
			abs_thr_q <= '0;
			rel_thr_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				angu_pkg::REG_SIZE_X:  size_x_q  <= cfg_data[4:0];
				angu_pkg::REG_SIZE_Y:  size_y_q  <= cfg_data[4:0];
				angu_pkg::REG_SIZE_Z:  size_z_q  <= cfg_data[4:0];
				angu_pkg::REG_ABS_THR: abs_thr_q <= cfg_data;
				angu_pkg::REG_REL_THR: rel_thr_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.sx      = clamp_size(size_x_q, GRID_X);
		cfg.sy      = clamp_size(size_y_q, GRID_Y);
		cfg.sz      = clamp_size(size_z_q, GRID_Z);
		cfg.abs_thr = abs_thr_q;
		cfg.rel_thr = rel_thr_q;
	end

	// sweep the store to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == (AW+1)'(CELLS - 1)) clearing_q <= 1'b0;
		end
	end

	assign item_stall = !eng_ready;

	angu_engine #(
		.GRID_X (GRID_X),
		.GRID_Y (GRID_Y),
		.GRID_Z (GRID_Z),
		.AW     (AW)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.enable      (!clearing_q),
		.item_valid  (item_valid),
		.item        (item),
		.ready       (eng_ready),
		.cfg         (cfg),
		.res_valid   (res_valid),
		.res         (res),
		.slot_free   (slot_free),
		.mem_rd_en   (e_rd_en),
		.mem_rd_addr (e_rd_addr),
		.mem_rd_data (rd_data),
		.mem_wr_en   (e_wr_en),
		.mem_wr_addr (e_wr_addr),
		.mem_wr_data (e_wr_data),
		.mem_wr_mask (e_wr_mask)
	);

	always_comb begin
		if (clearing_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q[AW-1:0];
			wr_data = '0;
			wr_mask = '1;
		end else begin
			wr_en   = e_wr_en;
			wr_addr = e_wr_addr;
			wr_data = e_wr_data;
			wr_mask = e_wr_mask;
		end
	end

	angu_ram #(
		.WIDTH (RW),
		.DEPTH (CELLS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.wr_mask (wr_mask),
		.rd_en   (e_rd_en),
		.rd_addr (e_rd_addr),
		.rd_data (rd_data)
	);

	// output register: refill whenever it is empty or the held transaction leaves
	assign slot_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (slot_free) begin
			result_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res_valid) result_q <= res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ hdl/angu_ram.sv @@
// Single-port-write, single-port-read node record memory with bit write mask.
module angu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [WIDTH-1:0] wr_mask,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < WIDTH; i++) begin
				if (wr_mask[i]) mem[wr_addr][i] <= wr_data[i];
			end
		end
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/angu_engine.sv @@
// Per-item sequencer: reads, updates and writes back node records.
module angu_engine #(
	parameter int GRID_X = 16,
	parameter int GRID_Y = 16,
	parameter int GRID_Z = 16,
	parameter int AW     = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 enable,
	input  logic                 item_valid,
	input  angu_pkg::in_item_t   item,
	output logic                 ready,
	input  angu_pkg::cfg_t       cfg,
	output logic                 res_valid,
	output angu_pkg::out_item_t  res,
	input  logic                 slot_free,
	output logic                 mem_rd_en,
	output logic [AW-1:0]        mem_rd_addr,
	input  angu_pkg::node_rec_t  mem_rd_data,
	output logic                 mem_wr_en,
	output logic [AW-1:0]        mem_wr_addr,
	output angu_pkg::node_rec_t  mem_wr_data,
	output angu_pkg::node_rec_t  mem_wr_mask
);

	localparam int STRIDE_X = GRID_Y * GRID_Z;
	localparam int STRIDE_Y = GRID_Z;
	localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISPATCH, ST_RD_WAIT, ST_INJ_ADD, ST_SQ_NEW, ST_SQ_OLD, ST_ENERGY,
		ST_LIMIT, ST_DECIDE, ST_DIV, ST_THIRD, ST_NB_RD, ST_NB_CAP, ST_NB_DONE,
		ST_CN_MUL, ST_CN_ACC, ST_SUM, ST_ACT_EMIT, ST_EMIT
	} state_t;

	state_t               state_q;
	angu_pkg::in_item_t   item_q;
	logic [AW-1:0]        cell_q;
	logic                 inrange_q;
	angu_pkg::node_rec_t  rec_q;
	angu_pkg::out_item_t  res_q;
	logic [2:0]           idx_q;
	logic [5:0]           act_q;
	logic [5:0][31:0]     nbout_q;
	logic [5:0][31:0]     pin_new_q;
	logic [31:0]          v_new_q;
	logic [63:0]          e_new_q, e_old_q, pe_new_q, pk_new_q, avg_q;
	logic [63:0]          lim_hi_q, quot_q;
	logic [15:0]          lim_lo_q;
	logic signed [47:0]   prod_r_q, prod_t_q;

	logic                 accept, is_scatter, nb_exists, plus, act_last, retire;
	logic [2:0]           act_idx, dir_sel;
	logic [1:0]           ax;
	logic [3:0]           pos, nb_pos, nb_x, nb_y, nb_z;
	logic [4:0]           lim;
	logic [AW-1:0]        stride, nb_addr;
	logic signed [63:0]   sq;
	logic [63:0]          sq_e, pe_n, pk_n, limit;
	logic [31:0]          mag, third;
	logic signed [49:0]   acc, sum;
	logic [5:0][31:0]     pout_n;

	function automatic logic [2:0] scat_dir(input logic [2:0] i);
		logic [2:0] d;
		case (i)
			3'd0: d = 3'd0;
			3'd1: d = 3'd2;
			3'd2: d = 3'd4;
			3'd3: d = 3'd1;
			3'd4: d = 3'd3;
			3'd5: d = 3'd5;
			default: d = 3'd0;
		endcase
		return d;
	endfunction

	assign ready      = (state_q == ST_IDLE) && enable;
	assign accept     = item_valid && ready;
	assign is_scatter = (item_q.action == angu_pkg::ACT_SCATTER);

	// lowest pending activation goes out first
	always_comb begin
		act_idx = 3'd0;
		for (int i = 5; i >= 0; i--) begin
			if (act_q[i]) act_idx = 3'(i);
		end
		act_last = ((act_q & ~(6'd1 << act_idx)) == 6'd0);
	end

	// neighbour geometry for the direction in hand
	always_comb begin
		if (state_q == ST_ACT_EMIT) dir_sel = scat_dir(act_idx);
		else if (is_scatter) dir_sel = scat_dir(idx_q);
		else dir_sel = idx_q;
		ax   = dir_sel[2:1];
		plus = !dir_sel[0];
		case (ax)
			2'd0: begin pos = item_q.node_x; lim = cfg.sx; stride = AW'(STRIDE_X); end
			2'd1: begin pos = item_q.node_y; lim = cfg.sy; stride = AW'(STRIDE_Y); end
			default: begin pos = item_q.node_z; lim = cfg.sz; stride = AW'(1); end
		endcase
		nb_exists = plus ? (({1'b0, pos} + 5'd1) < lim) : (pos != 4'd0);
		nb_addr   = plus ? cell_q + stride : cell_q - stride;
		nb_pos    = plus ? pos + 4'd1 : pos - 4'd1;
		nb_x      = (ax == 2'd0) ? nb_pos : item_q.node_x;
		nb_y      = (ax == 2'd1) ? nb_pos : item_q.node_y;
		nb_z      = (ax == 2'd2) ? nb_pos : item_q.node_z;
	end

	// arithmetic shared across states
	always_comb begin
		sq    = (state_q == ST_SQ_OLD) ? $signed(rec_q.volt) * $signed(rec_q.volt)
		                               : $signed(v_new_q) * $signed(v_new_q);
		sq_e  = {2'b00, sq[63:2]};
		pe_n  = angu_pkg::add_sat64(rec_q.pe, e_new_q);
		pk_n  = (pe_n > rec_q.pk) ? pe_n : rec_q.pk;
		limit = lim_hi_q + 64'(lim_lo_q);
		retire = (avg_q < cfg.abs_thr) || (avg_q < limit);
		mag   = rec_q.volt[31] ? (32'd0 - rec_q.volt) : rec_q.volt;
		third = rec_q.volt[31] ? (32'd0 - {1'b0, quot_q[63:33]}) : {1'b0, quot_q[63:33]};
		for (int p = 0; p < 6; p++) begin
			pout_n[p] = angu_pkg::sat32(50'($signed(third)) - 50'($signed(rec_q.pin[p])));
		end
		acc = 50'(prod_r_q) + 50'(prod_t_q) + 50'sd8192;
		sum = '0;
		for (int p = 0; p < 6; p++) begin
			sum = sum + 50'($signed(pin_new_q[p]));
		end
	end

	// memory port
	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = nb_addr;
		mem_wr_en   = 1'b0;
		mem_wr_addr = cell_q;
		mem_wr_data = '0;
		mem_wr_mask = '0;
		case (state_q)
			ST_DISPATCH: begin
				mem_rd_addr = cell_q;
				if (inrange_q) begin
					case (item_q.action)
						angu_pkg::ACT_SCATTER, angu_pkg::ACT_CONNECT, angu_pkg::ACT_INJECT:
							mem_rd_en = 1'b1;
						angu_pkg::ACT_SET_FLAGS: begin
							mem_wr_en               = 1'b1;
							mem_wr_mask.flags.prop  = 1'b1;
							mem_wr_mask.flags.bound = 1'b1;
							mem_wr_data.flags.prop  = item_q.may_propagate;
							mem_wr_data.flags.bound = item_q.has_boundary;
						end
						angu_pkg::ACT_LOAD_COEF: begin
							if (item_q.port_direction < angu_pkg::PORT_COUNT) begin
								mem_wr_en = 1'b1;
								mem_wr_mask.coef[item_q.port_direction] = '1;
								mem_wr_data.coef[item_q.port_direction].refl  = item_q.reflection;
								mem_wr_data.coef[item_q.port_direction].trans = item_q.transmission;
							end
						end
						default: mem_wr_en = 1'b0;
					endcase
				end
			end
			ST_NB_RD: mem_rd_en = nb_exists;
			ST_ENERGY: begin
				if (item_q.action == angu_pkg::ACT_INJECT) begin
					mem_wr_en                = 1'b1;
					mem_wr_mask.volt         = '1;
					mem_wr_mask.pe           = '1;
					mem_wr_mask.pk           = '1;
					mem_wr_mask.flags.active = 1'b1;
					mem_wr_data.volt         = v_new_q;
					mem_wr_data.pe           = pe_n;
					mem_wr_data.pk           = pk_n;
					mem_wr_data.flags.active = 1'b1;
				end
			end
			ST_THIRD: begin
				mem_wr_en        = 1'b1;
				mem_wr_mask.pout = '1;
				mem_wr_data.pout = pout_n;
			end
			ST_DECIDE: begin
				mem_wr_en                = 1'b1;
				mem_wr_mask.volt         = '1;
				mem_wr_mask.pin          = '1;
				mem_wr_mask.pout         = '1;
				mem_wr_mask.pe           = '1;
				mem_wr_mask.pk           = '1;
				mem_wr_mask.flags.active = 1'b1;
				mem_wr_data.pk           = pk_new_q;
				if (!retire) begin
					mem_wr_data.volt         = v_new_q;
					mem_wr_data.pin          = pin_new_q;
					mem_wr_data.pout         = rec_q.pout;
					mem_wr_data.pe           = pe_new_q;
					mem_wr_data.flags.active = 1'b1;
				end
			end
			ST_ACT_EMIT: begin
				mem_wr_en                = slot_free;
				mem_wr_addr              = nb_addr;
				mem_wr_mask.flags.active = 1'b1;
				mem_wr_data.flags.active = 1'b1;
			end
			default: mem_wr_en = 1'b0;
		endcase
	end

	assign res_valid = (state_q == ST_EMIT) || (state_q == ST_ACT_EMIT);

	always_comb begin
		res = res_q;
		if (state_q == ST_ACT_EMIT) begin
			res.kind            = angu_pkg::KIND_ACTIVATED;
			res.out_x           = nb_x;
			res.out_y           = nb_y;
			res.out_z           = nb_z;
			res.toward_positive = plus;
			res.last            = act_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			act_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q    <= item;
						cell_q    <= AW'((32'(item.node_x) * GRID_Y + 32'(item.node_y)) * GRID_Z
						                 + 32'(item.node_z));
						inrange_q <= ({1'b0, item.node_x} < cfg.sx) &&
						             ({1'b0, item.node_y} < cfg.sy) &&
						             ({1'b0, item.node_z} < cfg.sz);
						state_q   <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					res_q.kind            <= angu_pkg::KIND_DONE;
					res_q.out_x           <= item_q.node_x;
					res_q.out_y           <= item_q.node_y;
					res_q.out_z           <= item_q.node_z;
					res_q.toward_positive <= 1'b0;
					res_q.last            <= 1'b1;
					idx_q                 <= '0;
					act_q                 <= '0;
					if (inrange_q && (item_q.action == angu_pkg::ACT_SCATTER ||
					                  item_q.action == angu_pkg::ACT_CONNECT ||
					                  item_q.action == angu_pkg::ACT_INJECT))
						state_q <= ST_RD_WAIT;
					else
						state_q <= ST_EMIT;
				end
				ST_RD_WAIT: begin
					rec_q <= mem_rd_data;
					case (item_q.action)
						angu_pkg::ACT_INJECT:  state_q <= ST_INJ_ADD;
						angu_pkg::ACT_SCATTER: state_q <= ST_DIV;
						default:               state_q <= ST_NB_RD;
					endcase
				end
				ST_INJ_ADD: begin
					v_new_q <= angu_pkg::sat32(50'($signed(rec_q.volt)) + 50'(item_q.source_value));
					state_q <= ST_SQ_NEW;
				end
				ST_SQ_NEW: begin
					e_new_q <= sq_e;
					state_q <= (item_q.action == angu_pkg::ACT_CONNECT) ? ST_SQ_OLD : ST_ENERGY;
				end
				ST_SQ_OLD: begin
					e_old_q <= sq_e;
					state_q <= ST_ENERGY;
				end
				ST_ENERGY: begin
					pe_new_q <= pe_n;
					pk_new_q <= pk_n;
					avg_q    <= angu_pkg::add_sat64(e_new_q, e_old_q);
					state_q  <= (item_q.action == angu_pkg::ACT_CONNECT) ? ST_LIMIT : ST_EMIT;
				end
				ST_LIMIT: begin
					lim_hi_q <= 64'(pk_new_q[63:16]) * 64'(cfg.rel_thr);
					lim_lo_q <= 16'((32'(pk_new_q[15:0]) * 32'(cfg.rel_thr)) >> 16);
					state_q  <= ST_DECIDE;
				end
				ST_DECIDE: begin
					res_q.kind <= retire ? angu_pkg::KIND_RETIRED : angu_pkg::KIND_ACTIVE;
					state_q    <= ST_EMIT;
				end
				ST_DIV: begin
					quot_q  <= 64'(mag) * 64'(RECIP3);
					state_q <= ST_THIRD;
				end
				ST_THIRD: state_q <= ST_NB_RD;
				ST_NB_RD: begin
					if (nb_exists) begin
						state_q <= ST_NB_CAP;
					end else begin
						if (!is_scatter) nbout_q[idx_q] <= '0;
						if (idx_q == angu_pkg::LAST_PORT) state_q <= ST_NB_DONE;
						else idx_q <= idx_q + 3'd1;
					end
				end
				ST_NB_CAP: begin
					if (is_scatter)
						act_q[idx_q] <= !mem_rd_data.flags.active && mem_rd_data.flags.prop;
					else
						nbout_q[idx_q] <= mem_rd_data.pout[idx_q ^ 3'd1];
					if (idx_q == angu_pkg::LAST_PORT) begin
						state_q <= ST_NB_DONE;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= ST_NB_RD;
					end
				end
				ST_NB_DONE: begin
					idx_q <= '0;
					if (is_scatter) begin
						state_q <= (act_q == 6'd0) ? ST_EMIT : ST_ACT_EMIT;
					end else if (rec_q.flags.bound) begin
						state_q <= ST_CN_MUL;
					end else begin
						pin_new_q <= nbout_q;
						state_q   <= ST_SUM;
					end
				end
				ST_CN_MUL: begin
					prod_r_q <= rec_q.coef[idx_q].refl * $signed(rec_q.pout[idx_q]);
					prod_t_q <= rec_q.coef[idx_q].trans * $signed(nbout_q[idx_q]);
					state_q  <= ST_CN_ACC;
				end
				ST_CN_ACC: begin
					pin_new_q[idx_q] <= angu_pkg::sat32(acc >>> 14);
					if (idx_q == angu_pkg::LAST_PORT) begin
						state_q <= ST_SUM;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= ST_CN_MUL;
					end
				end
				ST_SUM: begin
					v_new_q <= angu_pkg::sat32(sum);
					state_q <= ST_SQ_NEW;
				end
				ST_ACT_EMIT: begin
					if (slot_free) begin
						act_q[act_idx] <= 1'b0;
						if (act_last) state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/angu_checker.sv @@
// Port-level checks for the active node grid update block, bound to the top level.
module angu_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 result_valid,
	input logic                 result_stall,
	input angu_pkg::out_item_t  result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result transaction changed");

	a_dir_only_on_activation: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != angu_pkg::KIND_ACTIVATED |-> !result.toward_positive)
		else $error("direction flag set on a non-activation result");

	a_connect_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind == angu_pkg::KIND_RETIRED ||
		                 result.kind == angu_pkg::KIND_ACTIVE) |-> result.last)
		else $error("connect result not marked last");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == angu_pkg::KIND_DONE |-> result.last)
		else $error("done result not marked last");

endmodule

bind tlm_active_node_grid_update angu_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
